// ===== src/knnq_pkg.sv =====
package knnq_pkg;

    localparam int MaxPoints  = 1024;
    localparam int MaxDim     = 16;
    localparam int MaxK       = 16;
    localparam int CoordWidth = 16;

    localparam int StoreDepth = MaxPoints * MaxDim;
    localparam int StoreAw    = $clog2(StoreDepth);
    localparam int PointW     = $clog2(MaxPoints);
    localparam int DimW       = $clog2(MaxDim);
    localparam int KW         = $clog2(MaxK);
    localparam int DiffW      = CoordWidth + 1;
    localparam int SqW        = 2 * CoordWidth;
    localparam int DistW      = 37;
    localparam int OutDistW   = 36;

    localparam logic [DistW-1:0] Infinity = '1;

    typedef enum logic [1:0]
    {
        REG_DIMS      = 2'd0,
        REG_REF_COUNT = 2'd1,
        REG_NEIGHB    = 2'd2,
        REG_SQUARED   = 2'd3
    } cfg_reg_t;

    typedef struct packed
    {
        logic [DistW-1:0]  sq_dist;
        logic [PointW-1:0] index;
    } cand_t;

endpackage

// ===== src/knnq_isqrt.sv =====
module knnq_isqrt
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [knnq_pkg::DistW-1:0]        value,
    output logic                              done,
    output logic [knnq_pkg::OutDistW-1:0]     root
);

    localparam int StepW = $clog2(knnq_pkg::DistW / 2 + 2);
    localparam int Steps = (knnq_pkg::DistW + 1) / 2;
    localparam int RemW  = knnq_pkg::DistW + 1;

    logic [RemW-1:0]                 rem_reg, rem_next;
    logic [RemW-1:0]                 val_reg, val_next;
    logic [knnq_pkg::OutDistW-1:0]   root_reg, root_next;
    logic [StepW-1:0]                step_reg, step_next;
    logic                            busy_reg, busy_next;
    logic                            done_reg, done_next;
    logic [RemW-1:0]                 trial;
    logic [RemW-1:0]                 shifted;

    always_comb
    begin
        shifted   = {rem_reg[RemW-3:0], val_reg[RemW-1 -: 2]};
        trial     = {root_reg[RemW-3:0], 2'b01};
        rem_next  = rem_reg;
        val_next  = val_reg;
        root_next = root_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            val_next  = RemW'(value);
            root_next = '0;
            step_next = StepW'(Steps);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            val_next = {val_reg[RemW-3:0], 2'b00};
            if (shifted >= trial)
            begin
                rem_next  = shifted - trial;
                root_next = {root_reg[knnq_pkg::OutDistW-2:0], 1'b1};
            end
            else
            begin
                rem_next  = shifted;
                root_next = {root_reg[knnq_pkg::OutDistW-2:0], 1'b0};
            end
            step_next = step_reg - 1'b1;
            if (step_reg == StepW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        val_reg  <= val_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// ===== src/knn_query_euclid.sv =====
// Loading and partial query beats are accepted back to back.
// A completing query beat holds s_tready low through the scan, one store read
// per cycle, through the pipeline drain and until the last result beat is taken.
// In square-root mode each result also waits for the bit-serial root;
// m_tready stalls hold each result beat until it is taken.
// rst_n clears positions and control, sets config registers to one; store contents stay undefined until loaded.
module knn_query_euclid
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // coordinate
    input  logic        s_tuser,   // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // distance, neighbour_index, rank, zero pad
    output logic        m_tlast,   // last
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [10:0] cfg_data
);

    localparam int PW  = knnq_pkg::PointW;
    localparam int DW  = knnq_pkg::DimW;
    localparam int KW  = knnq_pkg::KW;
    localparam int AW  = knnq_pkg::StoreAw;
    localparam int CW  = knnq_pkg::CoordWidth;
    localparam int XW  = knnq_pkg::DistW;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_EMIT,
        ST_ROOT,
        ST_OUT
    } state_t;

    typedef logic signed [CW:0] diff_t;

    state_t state_reg;

    logic [4:0]  dims_reg;
    logic [10:0] refc_reg;
    logic [4:0]  nb_reg;
    logic        sq_reg;

    logic [4:0]          d_eff;
    logic [PW:0]         n_eff;
    logic [KW:0]         k_eff;
    logic [AW:0]         limit;

    logic signed [CW-1:0] store_mem [knnq_pkg::StoreDepth];
    logic signed [CW-1:0] rd_data_reg;
    logic signed [CW-1:0] qbuf_mem [knnq_pkg::MaxDim];

    logic [AW:0]  load_pos_reg;
    logic [4:0]   qcount_reg;

    logic [AW-1:0] rd_addr_reg;
    logic [DW-1:0] rd_u_reg;
    logic [PW-1:0] rd_pt_reg;
    logic          rd_last_reg;
    logic          rd_valid_reg;
    logic          rd_end_reg;
    logic [AW:0]   scan_addr_reg;
    logic [DW:0]   scan_u_reg;
    logic [PW:0]   scan_pt_reg;

    logic signed [CW-1:0] q_reg;
    logic [PW-1:0]  s1_pt_reg;
    logic           s1_last_reg, s1_valid_reg, s1_end_reg;

    logic [CW:0]    s2_abs_reg;
    logic [PW-1:0]  s2_pt_reg;
    logic           s2_last_reg, s2_valid_reg, s2_end_reg;

    logic [2*CW+1:0] s3_sq_reg;
    logic [PW-1:0]   s3_pt_reg;
    logic            s3_last_reg, s3_valid_reg, s3_end_reg;

    logic [XW-1:0]   acc_reg;

    knnq_pkg::cand_t cand_reg;
    logic            cand_valid_reg, cand_end_reg;

    knnq_pkg::cand_t best_reg [knnq_pkg::MaxK];
    logic            ins_at [knnq_pkg::MaxK];
    logic            lt_at [knnq_pkg::MaxK];

    logic [KW:0]     out_i_reg;
    logic            root_start_reg;
    logic            root_done;
    logic [knnq_pkg::OutDistW-1:0] root_val;

    logic [knnq_pkg::OutDistW-1:0] o_dist_reg;
    logic [PW-1:0]   o_idx_reg;
    logic [KW-1:0]   o_rank_reg;
    logic            o_last_reg;

    logic s_fire, m_fire, is_query, query_done;
    logic [AW:0] lp_w;
    logic [knnq_pkg::DistW-1:0] root_in;

    always_comb
    begin
        d_eff = (dims_reg == 0) ? 5'd1 : (dims_reg > 5'(knnq_pkg::MaxDim))
              ? 5'(knnq_pkg::MaxDim) : dims_reg;
        n_eff = (refc_reg == 0) ? (PW+1)'(1) : (refc_reg > 11'(knnq_pkg::MaxPoints))
              ? (PW+1)'(knnq_pkg::MaxPoints) : (PW+1)'(refc_reg);
        k_eff = (nb_reg == 0) ? (KW+1)'(1) : (nb_reg > 5'(knnq_pkg::MaxK))
              ? (KW+1)'(knnq_pkg::MaxK) : (KW+1)'(nb_reg);
        if ((PW+1)'(k_eff) > n_eff)
            k_eff = (KW+1)'(n_eff);
        limit = (AW+1)'(n_eff) * (AW+1)'(d_eff);
    end

    assign s_tready   = (state_reg == ST_IDLE);
    assign s_fire     = s_tvalid && s_tready;
    assign m_fire     = m_tvalid && m_tready;
    assign is_query   = s_tuser;
    assign query_done = s_fire && is_query && ((qcount_reg >= 5'(knnq_pkg::MaxDim)) ||
                        (qcount_reg + 5'd1 >= d_eff));
    assign lp_w       = (load_pos_reg >= limit) ? '0 : load_pos_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dims_reg <= 5'd1;
            refc_reg <= 11'd1;
            nb_reg   <= 5'd1;
            sq_reg   <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (knnq_pkg::cfg_reg_t'(cfg_index))
                knnq_pkg::REG_DIMS:      dims_reg <= cfg_data[4:0];
                knnq_pkg::REG_REF_COUNT: refc_reg <= cfg_data;
                knnq_pkg::REG_NEIGHB:    nb_reg   <= cfg_data[4:0];
                knnq_pkg::REG_SQUARED:   sq_reg   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire && !is_query)
            store_mem[lp_w[AW-1:0]] <= s_tdata;
        rd_data_reg <= store_mem[rd_addr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (s_fire && is_query)
            qbuf_mem[(qcount_reg >= 5'(knnq_pkg::MaxDim)) ? DW'(0)
                     : qcount_reg[DW-1:0]] <= s_tdata;
        q_reg <= qbuf_mem[rd_u_reg];
    end

    always_comb
    begin
        for (int i = 0; i < knnq_pkg::MaxK; i++)
        begin
            lt_at[i] = (KW+1)'(i) < k_eff && cand_reg.sq_dist < best_reg[i].sq_dist;
        end
        for (int i = 0; i < knnq_pkg::MaxK; i++)
        begin
            ins_at[i] = lt_at[i] && ((i == 0) ? 1'b1 : !lt_at[(i == 0) ? 0 : i-1]);
        end
    end

    assign root_in = best_reg[0].sq_dist;

    knnq_isqrt u_isqrt
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (root_start_reg),
        .value (root_in),
        .done  (root_done),
        .root  (root_val)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            load_pos_reg   <= '0;
            qcount_reg     <= '0;
            scan_addr_reg  <= '0;
            scan_u_reg     <= '0;
            scan_pt_reg    <= '0;
            rd_valid_reg   <= 1'b0;
            rd_end_reg     <= 1'b0;
            s1_valid_reg   <= 1'b0;
            s1_end_reg     <= 1'b0;
            s2_valid_reg   <= 1'b0;
            s2_end_reg     <= 1'b0;
            s3_valid_reg   <= 1'b0;
            s3_end_reg     <= 1'b0;
            cand_valid_reg <= 1'b0;
            cand_end_reg   <= 1'b0;
            out_i_reg      <= '0;
            root_start_reg <= 1'b0;
            for (int i = 0; i < knnq_pkg::MaxK; i++)
            begin
                best_reg[i].sq_dist <= knnq_pkg::Infinity;
                best_reg[i].index   <= '0;
            end
        end
        else
        begin
            root_start_reg <= 1'b0;
            rd_valid_reg   <= 1'b0;
            rd_end_reg     <= 1'b0;
            s1_valid_reg   <= rd_valid_reg;
            s1_end_reg     <= rd_end_reg;
            s2_valid_reg   <= s1_valid_reg;
            s2_end_reg     <= s1_end_reg;
            s3_valid_reg   <= s2_valid_reg;
            s3_end_reg     <= s2_end_reg;
            cand_valid_reg <= s3_valid_reg && s3_last_reg;
            cand_end_reg   <= s3_end_reg;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_fire && !is_query)
                        load_pos_reg <= (lp_w + 1'b1 >= limit) ? '0 : lp_w + 1'b1;
                    if (s_fire && is_query)
                    begin
                        if (query_done)
                        begin
                            qcount_reg    <= '0;
                            scan_addr_reg <= '0;
                            scan_u_reg    <= '0;
                            scan_pt_reg   <= '0;
                            for (int i = 0; i < knnq_pkg::MaxK; i++)
                            begin
                                best_reg[i].sq_dist <= knnq_pkg::Infinity;
                                best_reg[i].index   <= '0;
                            end
                            state_reg <= ST_SCAN;
                        end
                        else if (qcount_reg >= 5'(knnq_pkg::MaxDim))
                            qcount_reg <= 5'd1;
                        else
                            qcount_reg <= qcount_reg + 5'd1;
                    end
                end
                ST_SCAN:
                begin
                    rd_valid_reg <= 1'b1;
                    rd_u_reg     <= scan_u_reg[DW-1:0];
                    rd_pt_reg    <= scan_pt_reg[PW-1:0];
                    rd_last_reg  <= (scan_u_reg + 1'b1 == (DW+1)'(d_eff));
                    scan_addr_reg <= scan_addr_reg + 1'b1;
                    if (scan_u_reg + 1'b1 == (DW+1)'(d_eff))
                    begin
                        scan_u_reg  <= '0;
                        scan_pt_reg <= scan_pt_reg + 1'b1;
                        if (scan_pt_reg + 1'b1 == n_eff)
                        begin
                            rd_end_reg <= 1'b1;
                            state_reg  <= ST_DRAIN;
                        end
                    end
                    else
                        scan_u_reg <= scan_u_reg + 1'b1;
                end
                ST_DRAIN:
                begin
                    if (cand_end_reg)
                    begin
                        out_i_reg <= '0;
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    if (sq_reg)
                        state_reg <= ST_OUT;
                    else
                    begin
                        root_start_reg <= 1'b1;
                        state_reg      <= ST_ROOT;
                    end
                end
                ST_ROOT:
                begin
                    if (root_done)
                        state_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (m_fire)
                    begin
                        for (int i = 0; i < knnq_pkg::MaxK - 1; i++)
                            best_reg[i] <= best_reg[i+1];
                        out_i_reg <= out_i_reg + 1'b1;
                        state_reg <= o_last_reg ? ST_IDLE : ST_EMIT;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
            if (cand_valid_reg)
            begin
                for (int i = 0; i < knnq_pkg::MaxK; i++)
                begin
                    if (ins_at[i])
                        best_reg[i] <= cand_reg;
                    else if (i > 0 && lt_at[i])
                        best_reg[i] <= best_reg[(i == 0) ? 0 : i-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s1_pt_reg   <= rd_pt_reg;
        s1_last_reg <= rd_last_reg;
        s2_abs_reg  <= (q_reg >= rd_data_reg)
                     ? (CW+1)'(unsigned'(diff_t'(q_reg) - diff_t'(rd_data_reg)))
                     : (CW+1)'(unsigned'(diff_t'(rd_data_reg) - diff_t'(q_reg)));
        s2_pt_reg   <= s1_pt_reg;
        s2_last_reg <= s1_last_reg;
        s3_sq_reg   <= s2_abs_reg * s2_abs_reg;
        s3_pt_reg   <= s2_pt_reg;
        s3_last_reg <= s2_last_reg;
        if (s3_valid_reg)
        begin
            if (s3_last_reg)
            begin
                cand_reg.sq_dist <= acc_reg + XW'(s3_sq_reg);
                cand_reg.index   <= s3_pt_reg;
                acc_reg          <= '0;
            end
            else
                acc_reg <= acc_reg + XW'(s3_sq_reg);
        end
        else if (state_reg == ST_IDLE)
            acc_reg <= '0;
        if (state_reg == ST_EMIT || (state_reg == ST_ROOT && root_done))
        begin
            o_dist_reg <= (state_reg == ST_ROOT) ? root_val
                        : best_reg[0].sq_dist[knnq_pkg::OutDistW-1:0];
            o_idx_reg  <= best_reg[0].index;
            o_rank_reg <= out_i_reg[KW-1:0];
            o_last_reg <= (out_i_reg + 1'b1 == k_eff);
        end
    end

    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = {6'd0, o_rank_reg, o_idx_reg, o_dist_reg};
    assign m_tlast  = o_last_reg;

    always_ff @(posedge clk)
        rd_addr_reg <= scan_addr_reg[AW-1:0];

endmodule

// ===== src/knnq_checker.sv =====
module knnq_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata,
    input logic        m_tlast
);

    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !s_tready)
        else $error("input taken while result pending");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped");

    a_rank: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=> !s_tready)
        else $error("early return to idle");

    a_rank0: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && m_tlast |=> s_tready)
        else $error("no return to idle");

endmodule

bind knn_query_euclid knnq_checker u_knnq_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
